@@ hw/rtl/integer_divide_modulo_unit_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef INTEGER_DIVIDE_MODULO_UNIT_MACROS_SVH
`define INTEGER_DIVIDE_MODULO_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IDM_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset.
`define IDM_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define IDM_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/idm_pkg.sv @@
`timescale 1ns / 1ps
package idm_pkg;

    localparam int WIDTH = 32;
    localparam int HALF  = 16;

    typedef enum logic [2:0] {
        OP_DIV32S = 3'd0,
        OP_DIV32U = 3'd1,
        OP_DIV16S = 3'd2,
        OP_MOD32S = 3'd3,
        OP_MOD32U = 3'd4,
        OP_MOD16S = 3'd5
    } idm_op_t;

    // Control that rides alongside each request through the pipeline
    typedef struct packed {
        logic neg_q;     // quotient needs negation
        logic neg_r;     // remainder needs negation
        logic want_rem;  // return remainder instead of quotient
        logic is16;      // sign-extend low half of the result
        logic zero;      // divisor was zero
        logic legal;     // operation code is defined
    } idm_ctrl_t;

    function automatic logic [WIDTH-1:0] sext_half(input logic [WIDTH-1:0] x);
        return {{(WIDTH - HALF){x[HALF-1]}}, x[HALF-1:0]};
    endfunction

endpackage

@@ hw/rtl/idm_pre.sv @@
`timescale 1ns / 1ps
module idm_pre (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic [2:0]                     in_operation,
    input  logic [idm_pkg::WIDTH-1:0]      in_dividend,
    input  logic [idm_pkg::WIDTH-1:0]      in_divisor,
    output logic                           out_valid,
    output idm_pkg::idm_ctrl_t             out_ctrl,
    output logic [idm_pkg::WIDTH-1:0]      out_mag_a,
    output logic [idm_pkg::WIDTH-1:0]      out_mag_b
);

    logic                      valid_reg;
    idm_pkg::idm_ctrl_t        ctrl_reg, ctrl_next;
    logic [idm_pkg::WIDTH-1:0] mag_a_reg, mag_a_next;
    logic [idm_pkg::WIDTH-1:0] mag_b_reg, mag_b_next;

    logic [idm_pkg::WIDTH-1:0] a_eff, b_eff;
    logic                      signed_op, narrow_a, narrow_b, is_mod;
    logic                      na, nb;

    // Decode the operation
    always_comb begin
        signed_op = 1'b0;
        narrow_a  = 1'b0;
        narrow_b  = 1'b0;
        is_mod    = 1'b0;
        ctrl_next = '0;
        unique case (in_operation)
            idm_pkg::OP_DIV32S: begin
                signed_op = 1'b1;
                ctrl_next.legal = 1'b1;
            end
            idm_pkg::OP_DIV32U: begin
                ctrl_next.legal = 1'b1;
            end
            idm_pkg::OP_DIV16S: begin
                signed_op = 1'b1;
                narrow_b  = 1'b1;
                ctrl_next.is16  = 1'b1;
                ctrl_next.legal = 1'b1;
            end
            idm_pkg::OP_MOD32S: begin
                signed_op = 1'b1;
                is_mod    = 1'b1;
                ctrl_next.legal = 1'b1;
            end
            idm_pkg::OP_MOD32U: begin
                is_mod    = 1'b1;
                ctrl_next.legal = 1'b1;
            end
            idm_pkg::OP_MOD16S: begin
                signed_op = 1'b1;
                narrow_a  = 1'b1;
                narrow_b  = 1'b1;
                is_mod    = 1'b1;
                ctrl_next.is16  = 1'b1;
                ctrl_next.legal = 1'b1;
            end
            default: begin
                ctrl_next.legal = 1'b0;
            end
        endcase

        // Form effective operands and their magnitudes
        a_eff = narrow_a ? idm_pkg::sext_half(in_dividend) : in_dividend;
        b_eff = narrow_b ? idm_pkg::sext_half(in_divisor) : in_divisor;
        na    = signed_op & a_eff[idm_pkg::WIDTH-1];
        nb    = signed_op & b_eff[idm_pkg::WIDTH-1];
        mag_a_next = na ? (~a_eff + 1'b1) : a_eff;
        mag_b_next = nb ? (~b_eff + 1'b1) : b_eff;

        ctrl_next.neg_q    = na ^ nb;
        ctrl_next.neg_r    = na;
        ctrl_next.want_rem = is_mod;
        ctrl_next.zero     = ctrl_next.legal && (b_eff == '0);
    end

    // Hold control valid under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl_reg  <= ctrl_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_mag_a = mag_a_reg;
    assign out_mag_b = mag_b_reg;

endmodule

@@ hw/rtl/idm_step.sv @@
`timescale 1ns / 1ps
module idm_step (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  idm_pkg::idm_ctrl_t        in_ctrl,
    input  logic [idm_pkg::WIDTH-1:0] in_rem,
    input  logic [idm_pkg::WIDTH-1:0] in_quo,
    input  logic [idm_pkg::WIDTH-1:0] in_div,
    output logic                      out_valid,
    output idm_pkg::idm_ctrl_t        out_ctrl,
    output logic [idm_pkg::WIDTH-1:0] out_rem,
    output logic [idm_pkg::WIDTH-1:0] out_quo,
    output logic [idm_pkg::WIDTH-1:0] out_div
);

    logic                      valid_reg;
    idm_pkg::idm_ctrl_t        ctrl_reg;
    logic [idm_pkg::WIDTH-1:0] rem_reg, rem_next;
    logic [idm_pkg::WIDTH-1:0] quo_reg, quo_next;
    logic [idm_pkg::WIDTH-1:0] div_reg;

    logic [idm_pkg::WIDTH:0]   shifted;
    logic [idm_pkg::WIDTH:0]   trial;
    logic                      fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        shifted  = {in_rem, in_quo[idm_pkg::WIDTH-1]};
        trial    = shifted - {1'b0, in_div};
        fits     = !trial[idm_pkg::WIDTH];
        rem_next = fits ? trial[idm_pkg::WIDTH-1:0] : shifted[idm_pkg::WIDTH-1:0];
        quo_next = {in_quo[idm_pkg::WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl_reg <= in_ctrl;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= in_div;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;

endmodule

@@ hw/rtl/idm_post.sv @@
`timescale 1ns / 1ps
module idm_post (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  idm_pkg::idm_ctrl_t        in_ctrl,
    input  logic [idm_pkg::WIDTH-1:0] in_rem,
    input  logic [idm_pkg::WIDTH-1:0] in_quo,
    output logic                      out_valid,
    output logic [idm_pkg::WIDTH-1:0] out_result,
    output logic                      out_zero
);

    logic                      valid_reg;
    logic [idm_pkg::WIDTH-1:0] result_reg, result_next;
    logic                      zero_reg;

    logic [idm_pkg::WIDTH-1:0] mag;
    logic                      neg;
    logic [idm_pkg::WIDTH-1:0] signed_val;

    // Pick quotient or remainder, restore sign, narrow when needed; zero for a bad code or zero divisor
    always_comb begin
        mag        = in_ctrl.want_rem ? in_rem : in_quo;
        neg        = in_ctrl.want_rem ? in_ctrl.neg_r : in_ctrl.neg_q;
        signed_val = neg ? (~mag + 1'b1) : mag;
        if (!in_ctrl.legal || in_ctrl.zero) begin
            result_next = '0;
        end else if (in_ctrl.is16) begin
            result_next = idm_pkg::sext_half(signed_val);
        end else begin
            result_next = signed_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
            zero_reg   <= in_ctrl.zero;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_zero   = zero_reg;

endmodule

@@ hw/rtl/integer_divide_modulo_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: 1 operand stage, 32 restoring divide stages at one quotient bit each,
// and 1 sign/select stage between request acceptance and result valid.
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous active-low aresetn clears all stage valid bits; data is not reset.
module integer_divide_modulo_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_operation,
    input  logic [idm_pkg::WIDTH-1:0] s_dividend,
    input  logic [idm_pkg::WIDTH-1:0] s_divisor,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [idm_pkg::WIDTH-1:0] m_result,
    output logic                      m_zero_divisor
);

    logic                      advance;
    logic                      valid_s [0:idm_pkg::WIDTH];
    idm_pkg::idm_ctrl_t        ctrl_s  [0:idm_pkg::WIDTH];
    logic [idm_pkg::WIDTH-1:0] rem_s   [0:idm_pkg::WIDTH];
    logic [idm_pkg::WIDTH-1:0] quo_s   [0:idm_pkg::WIDTH];
    logic [idm_pkg::WIDTH-1:0] div_s   [0:idm_pkg::WIDTH];

    // Move the pipe whenever the output slot is empty or being drained
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    idm_pre u_pre (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (s_valid),
        .in_operation (s_operation),
        .in_dividend  (s_dividend),
        .in_divisor   (s_divisor),
        .out_valid    (valid_s[0]),
        .out_ctrl     (ctrl_s[0]),
        .out_mag_a    (quo_s[0]),
        .out_mag_b    (div_s[0])
    );

    // Partial remainder starts at zero
    assign rem_s[0] = '0;

    for (genvar i = 0; i < idm_pkg::WIDTH; i++) begin : g_step
        idm_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_s[i]),
            .in_ctrl   (ctrl_s[i]),
            .in_rem    (rem_s[i]),
            .in_quo    (quo_s[i]),
            .in_div    (div_s[i]),
            .out_valid (valid_s[i+1]),
            .out_ctrl  (ctrl_s[i+1]),
            .out_rem   (rem_s[i+1]),
            .out_quo   (quo_s[i+1]),
            .out_div   (div_s[i+1])
        );
    end

    idm_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (valid_s[idm_pkg::WIDTH]),
        .in_ctrl    (ctrl_s[idm_pkg::WIDTH]),
        .in_rem     (rem_s[idm_pkg::WIDTH]),
        .in_quo     (quo_s[idm_pkg::WIDTH]),
        .out_valid  (m_valid),
        .out_result (m_result),
        .out_zero   (m_zero_divisor)
    );

endmodule

@@ hw/rtl/idm_checker.sv @@
`timescale 1ns / 1ps
`include "integer_divide_modulo_unit_macros.svh"
module idm_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [idm_pkg::WIDTH-1:0] m_result,
    input logic                      m_zero_divisor
);

    // A waiting result holds until taken
    `IDM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result) && $stable(m_zero_divisor))

    // A zero divisor always forces a zero result
    `IDM_ASSERT_IMPLY(a_zero_result, aclk, aresetn, m_valid && m_zero_divisor, m_result == '0)

    // An empty output slot never blocks new requests
    `IDM_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // Reset empties the output
    `IDM_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind integer_divide_modulo_unit idm_checker u_idm_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    localparam int       CLK_HALF_NS    = 5;
    localparam int       RESET_CYCLES   = 10;
    localparam int       RANDOM_ITEMS   = 1500;
    localparam int       PHASE_ITEMS    = 500;
    localparam int       HOLD_AT_ITEM   = 1100;
    localparam int       HOLD_CYCLES    = 300;
    localparam int       DRAIN_CYCLES   = 40;
    localparam int       WATCHDOG_LIMIT = 5000;
    // Codes outside the defined operation set
    localparam logic [2:0] OP_SPARE_LO  = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef struct {
        logic [2:0]                op;
        logic [idm_pkg::WIDTH-1:0] dividend;
        logic [idm_pkg::WIDTH-1:0] divisor;
    } div_request_t;

    typedef struct {
        logic [idm_pkg::WIDTH-1:0] result;
        logic                      zero_divisor;
    } div_outcome_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [2:0]                s_operation = '0;
    logic [idm_pkg::WIDTH-1:0] s_dividend = '0;
    logic [idm_pkg::WIDTH-1:0] s_divisor = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [idm_pkg::WIDTH-1:0] m_result;
    logic                      m_zero_divisor;

    div_request_t pending_requests[$];
    div_outcome_t expected_outcomes[$];
    div_request_t next_request;
    div_outcome_t oldest_outcome;
    int           requests_accepted = 0;
    int           total_requests = 0;
    int           sender_idle_pct = 23;
    int           receiver_idle_pct = 87;
    int           mismatches = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           quiet_cycles = 0;

    integer_divide_modulo_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_dividend     (s_dividend),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result),
        .m_zero_divisor (m_zero_divisor)
    );

    always #CLK_HALF_NS aclk = ~aclk;

    // Sign-extend the low half of a word
    function automatic logic [idm_pkg::WIDTH-1:0] widen_low_half(
        input logic [idm_pkg::WIDTH-1:0] x
    );
        return {{16{x[15]}}, x[15:0]};
    endfunction

    // Truncating signed divide on bit patterns; most negative / -1 wraps
    function automatic logic [idm_pkg::WIDTH-1:0] signed_quot_rem(
        input logic [idm_pkg::WIDTH-1:0] a,
        input logic [idm_pkg::WIDTH-1:0] b,
        input logic                      want_rem
    );
        logic [idm_pkg::WIDTH-1:0] mag_a;
        logic [idm_pkg::WIDTH-1:0] mag_b;
        logic [idm_pkg::WIDTH-1:0] quot;
        logic [idm_pkg::WIDTH-1:0] rem;
        mag_a = a[31] ? (32'd0 - a) : a;
        mag_b = b[31] ? (32'd0 - b) : b;
        quot  = mag_a / mag_b;
        rem   = mag_a % mag_b;
        if (want_rem)
            return a[31] ? (32'd0 - rem) : rem;
        return (a[31] ^ b[31]) ? (32'd0 - quot) : quot;
    endfunction

    // Work out the result the block must return for one request
    function automatic div_outcome_t divide_or_modulo(
        input logic [2:0]                op,
        input logic [idm_pkg::WIDTH-1:0] a,
        input logic [idm_pkg::WIDTH-1:0] b
    );
        div_outcome_t              o;
        logic [idm_pkg::WIDTH-1:0] b_half;
        logic [idm_pkg::WIDTH-1:0] a_half;
        o.result       = '0;
        o.zero_divisor = 1'b0;
        a_half         = widen_low_half(a);
        b_half         = widen_low_half(b);
        case (op)
            idm_pkg::OP_DIV32S: begin
                if (b == 0) o.zero_divisor = 1'b1;
                else o.result = signed_quot_rem(a, b, 1'b0);
            end
            idm_pkg::OP_DIV32U: begin
                if (b == 0) o.zero_divisor = 1'b1;
                else o.result = a / b;
            end
            idm_pkg::OP_DIV16S: begin
                if (b_half == 0) o.zero_divisor = 1'b1;
                else o.result = widen_low_half(signed_quot_rem(a, b_half, 1'b0));
            end
            idm_pkg::OP_MOD32S: begin
                if (b == 0) o.zero_divisor = 1'b1;
                else o.result = signed_quot_rem(a, b, 1'b1);
            end
            idm_pkg::OP_MOD32U: begin
                if (b == 0) o.zero_divisor = 1'b1;
                else o.result = a % b;
            end
            idm_pkg::OP_MOD16S: begin
                if (b_half == 0) o.zero_divisor = 1'b1;
                else o.result = widen_low_half(signed_quot_rem(a_half, b_half, 1'b1));
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    // Draw an operand biased toward the corners of the signed and half-width ranges
    function automatic logic [idm_pkg::WIDTH-1:0] pick_operand();
        logic [idm_pkg::WIDTH-1:0] v;
        case ($urandom_range(15))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_0001;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = 32'h7FFF_FFFF;
            5: begin
                v = $urandom_range(1, 300);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            6: begin
                v = $urandom;
                case ($urandom_range(3))
                    0: v[15:0] = 16'h0000;
                    1: v[15:0] = 16'h8000;
                    2: v[15:0] = 16'hFFFF;
                    default: v[15:0] = 16'h0001;
                endcase
            end
            7: v = widen_low_half($urandom);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_request(
        input logic [2:0]                op,
        input logic [idm_pkg::WIDTH-1:0] a,
        input logic [idm_pkg::WIDTH-1:0] b
    );
        div_request_t r;
        r.op       = op;
        r.dividend = a;
        r.divisor  = b;
        pending_requests.push_back(r);
    endtask

    // Offer requests from the pending queue; hold the payload until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(divide_or_modulo(s_operation, s_dividend,
                                                             s_divisor));
                requests_accepted <= requests_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    next_request = pending_requests.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= next_request.op;
                    s_dividend  <= next_request.dividend;
                    s_divisor   <= next_request.divisor;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest prediction; throttle m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result: result=%h zero_divisor=%b",
                           m_result, m_zero_divisor);
                    mismatches++;
                end else begin
                    oldest_outcome = expected_outcomes.pop_front();
                    if (m_result !== oldest_outcome.result) begin
                        $error("result: expected %h, got %h",
                               oldest_outcome.result, m_result);
                        mismatches++;
                    end
                    if (m_zero_divisor !== oldest_outcome.zero_divisor) begin
                        $error("zero_divisor: expected %b, got %b",
                               oldest_outcome.zero_divisor, m_zero_divisor);
                        mismatches++;
                    end
                end
            end
            // Hold off once for long enough to back up the whole pipe
            if (!hold_done && requests_accepted >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[integer_divide_modulo_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        // Directed corners: zero divisors, signed wrap, sign of remainder, half width, spare codes
        add_request(idm_pkg::OP_DIV32S, 32'h8000_0000, 32'hFFFF_FFFF);
        add_request(idm_pkg::OP_MOD32S, 32'h8000_0000, 32'hFFFF_FFFF);
        add_request(idm_pkg::OP_DIV16S, 32'h8000_0000, 32'h0000_FFFF);
        add_request(idm_pkg::OP_MOD16S, 32'h1234_8000, 32'hABCD_FFFF);
        add_request(idm_pkg::OP_DIV32S, 32'h0000_0000, 32'h0000_0000);
        add_request(idm_pkg::OP_DIV32U, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(idm_pkg::OP_DIV16S, 32'h7FFF_FFFF, 32'h1234_0000);
        add_request(idm_pkg::OP_MOD32S, 32'h1234_5678, 32'h0000_0000);
        add_request(idm_pkg::OP_MOD32U, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(idm_pkg::OP_MOD16S, 32'hFFFF_FFFF, 32'hFFFF_0000);
        add_request(idm_pkg::OP_DIV32S, 32'hFFFF_FFF9, 32'h0000_0002);
        add_request(idm_pkg::OP_MOD32S, 32'hFFFF_FFF9, 32'h0000_0002);
        add_request(idm_pkg::OP_MOD32S, 32'h0000_0007, 32'hFFFF_FFFE);
        add_request(idm_pkg::OP_DIV32U, 32'hFFFF_FFFF, 32'h0000_0001);
        add_request(idm_pkg::OP_DIV32U, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(idm_pkg::OP_MOD32U, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_request(idm_pkg::OP_DIV16S, 32'h7FFF_FFFF, 32'h0000_0001);
        add_request(idm_pkg::OP_DIV16S, 32'hFFFF_0000, 32'h0000_8000);
        add_request(idm_pkg::OP_MOD16S, 32'h0000_7FFF, 32'h0000_8000);
        add_request(idm_pkg::OP_MOD16S, 32'hFFFF_8001, 32'h0000_0007);
        add_request(idm_pkg::OP_DIV32S, 32'h7FFF_FFFF, 32'h8000_0000);
        add_request(OP_SPARE_LO, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(OP_SPARE_HI, 32'h1234_5678, 32'h0000_0003);

        // Random mix of all operations, a few spare codes among them
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            logic [2:0] op;
            if ($urandom_range(31) == 0)
                op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
            else
                op = 3'($urandom_range(5));
            add_request(op, pick_operand(), pick_operand());
        end
        total_requests = pending_requests.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Swap the idle pattern, then run without idling
        wait (requests_accepted >= PHASE_ITEMS);
        sender_idle_pct   = 87;
        receiver_idle_pct = 23;
        wait (requests_accepted >= 2 * PHASE_ITEMS);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;

        wait (requests_accepted == total_requests);
        wait (expected_outcomes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[integer_divide_modulo_unit] OK");
        else
            $display("[integer_divide_modulo_unit] ERROR");
        $finish;
    end

endmodule
